// ----- rtl/text_console_writer_core_macros.svh -----
// Assertion macros used by the top level of the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// Shared types, constants and codes of the text console writer.
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 24;
    localparam int TAB_STOP = 4;
    localparam int CELLS    = ROWS * COLUMNS;

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int SUM_W   = ADDR_W + 1;
    localparam int PHASE_W = $clog2(TAB_STOP);
    localparam int TABN_W  = $clog2(TAB_STOP + 1);

    // Fixed field widths.
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int POS_W  = 11;
    localparam int DATA_W = 16;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Reset values.
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [DATA_W-1:0] RESET_CELL = 16'h0720;

    // Item modes.
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] character;
        logic [POS_W-1:0]  cell_address;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [DATA_W-1:0] cell_data;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_READ,
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE,
        OP_TAB
    } t_op;

    // Classified command as it travels through the queue.
    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  addr;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_RDATA,
        ST_SCROLL,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/tcw_front.sv -----
// Front end: accepts input items, classifies them into commands and holds one for the queue.
module tcw_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tcw_pkg::t_in_item i_in_item,
    input  logic            i_clearing,
    output logic            o_cmd_valid,
    output tcw_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_ready
);
    import tcw_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // No item is taken while the store is being cleared.
    assign o_in_ready = !i_clearing && (!r_valid || i_cmd_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Classify the item; a tab is carried out as a run of spaces.
    always_comb begin
        n_cmd.ch   = i_in_item.character;
        n_cmd.addr = i_in_item.cell_address;
        n_cmd.op   = OP_PUT;
        if (i_in_item.mode == MODE_READ) begin
            n_cmd.op = OP_READ;
        end else begin
            unique case (i_in_item.character)
                CH_NEWLINE:   n_cmd.op = OP_NEWLINE;
                CH_RETURN:    n_cmd.op = OP_RETURN;
                CH_BACKSPACE: n_cmd.op = OP_BACKSPACE;
                CH_TAB: begin
                    n_cmd.op = OP_TAB;
                    n_cmd.ch = CH_SPACE;
                end
                default:      n_cmd.op = OP_PUT;
            endcase
        end
    end

    // Holding register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Holding register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ----- rtl/tcw_queue.sv -----
// Short command queue between the front end and the execution back end.
module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output tcw_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import tcw_pkg::*;

    t_cmd              r_entry [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_ok;
    logic              pop_ok;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] result;
        if (ptr == QPTR_W'(QDEPTH - 1)) begin
            result = '0;
        end else begin
            result = ptr + QPTR_W'(1);
        end
        return result;
    endfunction

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (pop_ok) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/tcw_back.sv -----
// Back end: carries out commands on the cell store, keeps the cursor and drives results.
module tcw_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_data,
    input  logic                         i_q_valid,
    input  tcw_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_clearing,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output tcw_pkg::t_out_item           o_out_item
);
    import tcw_pkg::*;

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'((COLUMNS - 1) % TAB_STOP);

    // Cell store; rows are kept as a ring starting at r_base.
    logic [DATA_W-1:0] mem [CELLS];
    logic [DATA_W-1:0] r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0]  r_waddr, n_waddr;
    logic [COL_W-1:0]   r_cnt, n_cnt;
    logic [TABN_W-1:0]  r_n, n_n;
    logic [DATA_W-1:0]  r_data, n_data;
    logic [ATTR_W-1:0]  r_attr;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [ADDR_W-1:0] cur_lin;
    logic [ADDR_W-1:0] cur_phys;
    logic [ADDR_W-1:0] rd_phys;
    logic              rd_in_range;
    logic [SUM_W-1:0]  base_sum;
    logic [ADDR_W-1:0] base_next;
    logic              col_last;
    logic              row_last;
    logic              phase_last;
    logic              load_out;
    logic              pop;

    // Logical position to ring position.
    function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] lin,
                                                  input logic [ADDR_W-1:0] base);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, lin} + {1'b0, base};
        if (sum >= SUM_W'(CELLS)) begin
            sum = sum - SUM_W'(CELLS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Cursor and read addresses.
    assign cur_lin     = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign cur_phys    = to_phys(cur_lin, r_base);
    assign rd_in_range = (32'(r_cmd.addr) < 32'(CELLS));
    assign rd_phys     = to_phys(ADDR_W'(r_cmd.addr), r_base);

    // Ring start after a scroll.
    assign base_sum  = {1'b0, r_base} + SUM_W'(COLUMNS);
    assign base_next = (base_sum == SUM_W'(CELLS)) ? '0 : base_sum[ADDR_W-1:0];

    assign col_last   = (r_col == COL_W'(COLUMNS - 1));
    assign row_last   = (r_row == ROW_W'(ROWS - 1));
    assign phase_last = (r_phase == PHASE_W'(TAB_STOP - 1));

    // A finished item moves to the output register once it is free.
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign pop      = i_q_valid && ((r_state == ST_IDLE) || load_out);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_waddr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (r_cmd.op)
                    OP_READ:      n_state = rd_in_range ? ST_RDATA : ST_DONE;
                    OP_PUT, OP_TAB: begin
                        if (col_last && row_last) begin
                            n_state = ST_SCROLL;
                        end else if (r_n == TABN_W'(1)) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_EXEC;
                        end
                    end
                    OP_NEWLINE:   n_state = row_last ? ST_SCROLL : ST_DONE;
                    OP_RETURN:    n_state = ST_DONE;
                    OP_BACKSPACE: n_state = ST_BLANK;
                    default:      n_state = ST_DONE;
                endcase
            end
            ST_BLANK: n_state = ST_DONE;
            ST_RDATA: n_state = ST_DONE;
            ST_SCROLL: begin
                if (r_cnt == COL_W'(COLUMNS - 1)) begin
                    n_state = (r_n != '0) ? ST_EXEC : ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = i_q_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and store controls for each state.
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_phase   = r_phase;
        n_base    = r_base;
        n_waddr   = r_waddr;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_data    = r_data;
        mem_we    = 1'b0;
        mem_waddr = cur_phys;
        mem_wdata = {r_attr, CH_SPACE};

        // Set up the space count of a newly taken command.
        if (pop) begin
            n_data = '0;
            unique case (i_q_cmd.op)
                OP_TAB:  n_n = TABN_W'(TAB_STOP) - TABN_W'(r_phase);
                OP_PUT:  n_n = TABN_W'(1);
                default: n_n = '0;
            endcase
        end

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                mem_wdata = RESET_CELL;
                n_waddr   = r_waddr + ADDR_W'(1);
            end
            ST_EXEC: begin
                unique case (r_cmd.op)
                    OP_PUT, OP_TAB, OP_NEWLINE: begin
                        if (r_cmd.op != OP_NEWLINE) begin
                            mem_we    = 1'b1;
                            mem_wdata = {r_attr, r_cmd.ch};
                            n_n       = r_n - TABN_W'(1);
                        end
                        if (col_last || r_cmd.op == OP_NEWLINE) begin
                            // Move to the start of the next row, scrolling at the bottom.
                            n_col   = '0;
                            n_phase = '0;
                            if (row_last) begin
                                n_base  = base_next;
                                n_waddr = r_base;
                                n_cnt   = '0;
                            end else begin
                                n_row = r_row + ROW_W'(1);
                            end
                        end else begin
                            n_col   = r_col + COL_W'(1);
                            n_phase = phase_last ? '0 : r_phase + PHASE_W'(1);
                        end
                    end
                    OP_RETURN: begin
                        n_col   = '0;
                        n_phase = '0;
                    end
                    OP_BACKSPACE: begin
                        if (r_col != '0) begin
                            n_col   = r_col - COL_W'(1);
                            n_phase = (r_phase == '0) ? PHASE_W'(TAB_STOP - 1)
                                                      : r_phase - PHASE_W'(1);
                        end else if (r_row != '0) begin
                            n_row   = r_row - ROW_W'(1);
                            n_col   = COL_W'(COLUMNS - 1);
                            n_phase = PHASE_LAST;
                        end
                    end
                    default: begin
                        // A read only addresses the store here.
                    end
                endcase
            end
            ST_BLANK: begin
                mem_we = 1'b1;
            end
            ST_RDATA: begin
                n_data = r_rdata;
            end
            ST_SCROLL: begin
                mem_we    = 1'b1;
                mem_waddr = r_waddr;
                n_waddr   = r_waddr + ADDR_W'(1);
                n_cnt     = r_cnt + COL_W'(1);
            end
            default: begin
                // Idle and done leave the datapath alone.
            end
        endcase
    end

    // Cell store write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Cell store read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_phys];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_base      <= '0;
            r_waddr     <= '0;
            r_n         <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_phase <= n_phase;
            r_base  <= n_base;
            r_waddr <= n_waddr;
            r_n     <= n_n;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_data <= n_data;
        if (pop) begin
            r_cmd <= i_q_cmd;
        end
        if (load_out) begin
            r_out_item.cursor_position <= POS_W'(cur_lin);
            r_out_item.cell_data       <= r_data;
        end
    end

    assign o_q_pop     = pop;
    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Top level of the text console writer: front end, command queue and back end.
//
// Input items arrive on i_in_valid / o_in_ready with payload i_in_item. A put item
// (mode 0) prints one character byte with the control codes newline, return,
// backspace and tab; a read item (mode 1) returns one cell of the 24 by 80 store.
// Each item gives one result on o_out_valid / i_out_ready: the cursor position after
// the item and, for a read, the cell with attribute high and character low.
// The attribute for new cells is written on i_cfg_valid; the user is to write it
// only while the block is idle, and the block itself does not enforce this.
// o_cfg_ready is always high. A tab is carried out one space after another, and a
// scroll clears the new bottom row one cell a cycle. The cell store has a single
// write port. After reset the store is cleared to grey blanks, one cell a cycle,
// and no item is accepted meanwhile. A stalled result waits in the output register
// while up to three further items are taken in and the next one is worked.
module text_console_writer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tcw_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tcw_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_data
);
    import tcw_pkg::*;

`include "text_console_writer_core_macros.svh"

    logic clearing;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_ready;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // Attribute writes are always taken.
    assign o_cfg_ready = 1'b1;

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_clearing  (clearing),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .o_ready (cmd_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // No item enters while the store is being cleared.
    `TCW_ASSERT_SAME(a_no_accept_clearing, clearing, !(i_in_valid && o_in_ready), "item accepted during store clear")
    // The back end takes no command before the clearing pass is over.
    `TCW_ASSERT_SAME(a_no_pop_clearing, q_pop, !clearing && q_valid, "command taken during clear or from empty queue")
    // A command pushed into the queue is there in the next cycle.
    `TCW_ASSERT_NEXT(a_push_visible, cmd_valid && cmd_ready, q_valid, "queue empty after a push")
    // The reported cursor always lies inside the screen.
    `TCW_ASSERT_SAME(a_cursor_range, o_out_valid, 32'(o_out_item.cursor_position) < 32'(CELLS), "cursor position off screen")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the text console writer: directed probes, then paced random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 120;
    localparam int MAX_REPORTS    = 10;
    localparam int N_PROBES       = 22;

    // One directed probe; the typed result is used only where typed_ok is set.
    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  addr;
        logic              typed_ok;
        logic [POS_W-1:0]  want_pos;
        logic [DATA_W-1:0] want_data;
    } t_probe;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_item = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_item;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [ATTR_W-1:0] i_cfg_data = '0;

    // Shadow copy of the console: cell store, cursor and attribute.
    logic [DATA_W-1:0] shadow_cells [CELLS];
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [ATTR_W-1:0] cur_attr;

    t_out_item console_results_due [$];

    int failures          = 0;
    int results_seen      = 0;
    int items_sent        = 0;
    int reads_sent        = 0;
    int scroll_count      = 0;
    int tab_count         = 0;
    int attr_writes       = 0;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int holdoffs_asked    = 0;
    int holdoffs_served   = 0;
    int holdoff_left      = 0;

    t_probe probes [N_PROBES] = '{
        '{MODE_READ, 8'h00, 11'd0,    1'b1, 11'd0,  RESET_CELL},
        '{MODE_READ, 8'hFF, 11'd1919, 1'b1, 11'd0,  RESET_CELL},
        '{MODE_READ, 8'h00, 11'd1920, 1'b1, 11'd0,  16'h0000},
        '{MODE_READ, 8'h5A, 11'd2047, 1'b1, 11'd0,  16'h0000},
        '{MODE_PUT,  CH_BACKSPACE, 11'd2047, 1'b1, 11'd0, 16'h0000},
        '{MODE_READ, 8'h00, 11'd0,    1'b1, 11'd0,  RESET_CELL},
        '{MODE_PUT,  8'h41, 11'h555,  1'b1, 11'd1,  16'h0000},
        '{MODE_PUT,  8'hFF, 11'h2AA,  1'b1, 11'd2,  16'h0000},
        '{MODE_PUT,  8'h00, 11'd0,    1'b1, 11'd3,  16'h0000},
        '{MODE_PUT,  CH_TAB, 11'd0,   1'b1, 11'd4,  16'h0000},
        '{MODE_PUT,  CH_TAB, 11'd0,   1'b1, 11'd8,  16'h0000},
        '{MODE_READ, 8'h00, 11'd0,    1'b1, 11'd8,  16'h0741},
        '{MODE_READ, 8'h00, 11'd1,    1'b0, 11'd0,  16'h0000},
        '{MODE_READ, 8'h00, 11'd5,    1'b0, 11'd0,  16'h0000},
        '{MODE_PUT,  CH_RETURN, 11'd0,    1'b1, 11'd0,  16'h0000},
        '{MODE_PUT,  CH_NEWLINE, 11'd0,   1'b1, 11'd80, 16'h0000},
        '{MODE_PUT,  CH_BACKSPACE, 11'd0, 1'b1, 11'd79, 16'h0000},
        '{MODE_READ, 8'h00, 11'd79,   1'b0, 11'd0,  16'h0000},
        '{MODE_PUT,  8'h7E, 11'd0,    1'b0, 11'd0,  16'h0000},
        '{MODE_PUT,  CH_TAB, 11'd0,   1'b0, 11'd0,  16'h0000},
        '{MODE_READ, 8'h00, 11'd80,   1'b0, 11'd0,  16'h0000},
        '{MODE_READ, 8'h00, 11'd1919, 1'b0, 11'd0,  16'h0000}
    };

    text_console_writer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard limit on the run.
    initial begin
        #10ms;
        $display("Timeout with %0d results still outstanding.", console_results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Blank cell in the current attribute.
    function automatic logic [DATA_W-1:0] blank_cell();
        return {cur_attr, CH_SPACE};
    endfunction

    // Move to column 0 of the next row, scrolling the store up past the last row.
    function automatic void line_feed();
        int i;
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (int'(cur_row) < ROWS) return;
        for (i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) shadow_cells[i] = blank_cell();
        cur_row = ROW_W'(ROWS - 1);
        scroll_count++;
    endfunction

    // Write one character at the cursor and advance, wrapping at the row end.
    function automatic void print_glyph(input logic [CHAR_W-1:0] ch);
        shadow_cells[int'(cur_row) * COLUMNS + int'(cur_col)] = {cur_attr, ch};
        cur_col = cur_col + 1'b1;
        if (int'(cur_col) >= COLUMNS) line_feed();
    endfunction

    // Apply one item to the shadow console and return the result it should give.
    function automatic t_out_item console_step(input t_in_item it);
        t_out_item res;
        int        spaces;
        res.cell_data = '0;
        if (it.mode == MODE_READ) begin
            if (int'(it.cell_address) < CELLS) res.cell_data = shadow_cells[it.cell_address];
        end else begin
            case (it.character)
                CH_NEWLINE: begin
                    line_feed();
                end
                CH_RETURN: begin
                    cur_col = '0;
                end
                CH_BACKSPACE: begin
                    if (cur_col > 0) begin
                        cur_col = cur_col - 1'b1;
                    end else if (cur_row > 0) begin
                        cur_row = cur_row - 1'b1;
                        cur_col = COL_W'(COLUMNS - 1);
                    end
                    shadow_cells[int'(cur_row) * COLUMNS + int'(cur_col)] = blank_cell();
                end
                CH_TAB: begin
                    // The space count is fixed on arrival; each space may wrap or scroll.
                    spaces = TAB_STOP - (int'(cur_col) % TAB_STOP);
                    tab_count++;
                    while (spaces > 0) begin
                        print_glyph(CH_SPACE);
                        spaces--;
                    end
                end
                default: begin
                    print_glyph(it.character);
                end
            endcase
        end
        res.cursor_position = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
        return res;
    endfunction

    function automatic t_in_item put_item(input logic [CHAR_W-1:0] ch);
        t_in_item it;
        it.mode         = MODE_PUT;
        it.character    = ch;
        it.cell_address = POS_W'($urandom_range(2047));
        return it;
    endfunction

    // Reads favor cells just written, with some full-range and out-of-range addresses.
    function automatic t_in_item read_item();
        t_in_item it;
        int       roll;
        int       here;
        int       a;
        roll = $urandom_range(9);
        here = int'(cur_row) * COLUMNS + int'(cur_col);
        if (roll < 4) begin
            a = here - int'($urandom_range(160));
            if (a < 0) a = 0;
        end else if (roll < 8) begin
            a = int'($urandom_range(CELLS - 1));
        end else begin
            a = int'($urandom_range(2047, CELLS));
        end
        it.mode         = MODE_READ;
        it.character    = CHAR_W'($urandom_range(255));
        it.cell_address = POS_W'(a);
        return it;
    endfunction

    // Offer one item, with a random gap first, and record its result once accepted.
    task automatic send_item(input t_in_item it, input logic typed_ok, input t_out_item typed);
        t_out_item predicted;
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = console_step(it);
        console_results_due.push_back(typed_ok ? typed : predicted);
        items_sent++;
        if (it.mode == MODE_READ) reads_sent++;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (console_results_due.size() != 0);
    endtask

    // Attribute write with the block idle, after any trailing scroll has finished.
    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_attr = value;
        attr_writes++;
    endtask

    // Random traffic in bursts: text lines, backspaces, reads, newline runs and noise.
    task automatic run_phase(input logic [ATTR_W-1:0] attr, input int idle_pct,
                             input int stall_pct, input int count,
                             input int hold_at, input int pause_at);
        int       done_n;
        int       kind;
        int       len;
        int       i;
        int       roll;
        t_in_item it;
        set_attribute(attr);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        done_n = 0;
        while (done_n < count) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(100, 60) : $urandom_range(20, 1);
            end else if (kind < 50) begin
                len = $urandom_range(6, 1);
            end else if (kind < 70) begin
                len = $urandom_range(4, 1);
            end else if (kind < 80) begin
                len = $urandom_range(12, 1);
            end else begin
                len = 1;
            end
            for (i = 0; i < len && done_n < count; i++) begin
                if (kind < 40) begin
                    roll = $urandom_range(99);
                    if (i == len - 1 && roll < 80) begin
                        it = put_item((roll < 20) ? CH_RETURN : CH_NEWLINE);
                    end else if (roll < 12) begin
                        it = put_item(CH_TAB);
                    end else if (roll < 16) begin
                        it = put_item(CHAR_W'($urandom_range(255)));
                    end else begin
                        it = put_item(CHAR_W'($urandom_range(126, 32)));
                    end
                end else if (kind < 50) begin
                    it = put_item(CH_BACKSPACE);
                end else if (kind < 70) begin
                    it = read_item();
                end else if (kind < 80) begin
                    it = put_item(CH_NEWLINE);
                end else begin
                    it.mode         = 1'($urandom_range(1));
                    it.character    = CHAR_W'($urandom_range(255));
                    it.cell_address = POS_W'($urandom_range(2047));
                end
                if (done_n == hold_at) holdoffs_asked++;
                if (done_n == pause_at) wait_all_results();
                send_item(it, 1'b0, '0);
                done_n++;
            end
        end
    endtask

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            i_out_ready  <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoffs_served != holdoffs_asked) begin
            i_out_ready     <= 1'b0;
            holdoff_left    <= HOLDOFF_CYCLES;
            holdoffs_served <= holdoffs_served + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compare each accepted result with the oldest outstanding one.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (console_results_due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Unexpected result %0d: cursor_position %0d cell_data %h",
                             results_seen, o_out_item.cursor_position, o_out_item.cell_data);
            end else begin
                want = console_results_due.pop_front();
                if (o_out_item.cursor_position !== want.cursor_position ||
                    o_out_item.cell_data !== want.cell_data) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("Result %0d: cursor_position exp %0d got %0d, cell_data exp %h got %h",
                                 results_seen, want.cursor_position,
                                 o_out_item.cursor_position, want.cell_data,
                                 o_out_item.cell_data);
                end
            end
        end
    end

    // Main sequence: reset, directed probes, four paced random phases, drain.
    initial begin
        int k;
        for (k = 0; k < CELLS; k++) shadow_cells[k] = RESET_CELL;
        cur_row  = '0;
        cur_col  = '0;
        cur_attr = ATTR_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_PROBES; k++)
            send_item({probes[k].mode, probes[k].ch, probes[k].addr}, probes[k].typed_ok,
                      {probes[k].want_pos, probes[k].want_data});

        run_phase(8'h00, 0, 0, 130, -1, -1);
        run_phase(8'hFF, 56, 0, 130, -1, -1);
        run_phase(ATTR_W'($urandom_range(255)), 0, 56, 130, 40, -1);
        run_phase(ATTR_W'($urandom_range(255)), 11, 11, 135, -1, 60);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (console_results_due.size() != 0) begin
            failures += console_results_due.size();
            $display("%0d results never arrived.", console_results_due.size());
        end
        $display("Sent %0d items (%0d reads, %0d tabs) causing %0d scrolls; %0d results checked.",
                 items_sent, reads_sent, tab_count, scroll_count, results_seen);
        $display("%0d attribute writes, four pacing phases, %0d long result hold-offs.",
                 attr_writes, holdoffs_served);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
